// ===== sv/led_driver_two_wire_serializer_core_defines.svh =====
// Assertion macros for the two-wire LED driver serializer.
// Included by files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef LED_DRIVER_TWO_WIRE_SERIALIZER_CORE_DEFINES_SVH
`define LED_DRIVER_TWO_WIRE_SERIALIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LDTW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("serializer assertion failed");

// Next-cycle implication, disabled during reset.
`define LDTW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("serializer assertion failed");

`endif

// ===== sv/ldtw_pkg.sv =====
// Shared types, codes and helpers of the two-wire LED driver serializer.
// No dependencies; used by scoped names except in header and interfaces.
package ldtw_pkg;

  typedef enum logic [1:0] {
    OP_CMD  = 2'd0,
    OP_ADDR = 2'd1,
    OP_DATA = 2'd2,
    OP_BRT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_OPEN = 2'd1,
    MODE_DROP = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_START = 2'd1,
    BK_BITS  = 2'd2,
    BK_STOP  = 2'd3
  } phase_t;

  localparam logic [7:0] ADDR_BASE  = 8'hC0;
  localparam logic [7:0] BRT_BASE   = 8'h80;
  localparam logic [7:0] BRT_ON     = 8'h08;
  localparam logic [7:0] BRT_MAX    = 8'h08;
  localparam logic [7:0] ADDR_MAX   = 8'd15;
  localparam logic [7:0] BRT_OFFSET = 8'h01;

  // One queued job: optional start, eight bits, optional stop.
  typedef struct packed {
    logic       start;
    logic       stop;
    logic [7:0] byte_val;
  } job_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  function automatic logic [7:0] brt_encode(input logic [7:0] value);
    logic [7:0] b;
    b = (value > BRT_MAX) ? BRT_MAX : value;
    if (b != 8'd0) begin
      b = (b - BRT_OFFSET) | BRT_ON;
    end
    return BRT_BASE | b;
  endfunction

endpackage

// ===== sv/ldtw_chan_if.sv =====
// Valid/ready channel interfaces for requests and pin steps.
// No dependencies.
interface ldtw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] value;
  logic       last;

  modport source (output valid, output operation, output value, output last, input ready);
  modport sink   (input valid, input operation, input value, input last, output ready);
endinterface

interface ldtw_out_if;
  logic valid;
  logic ready;
  logic clock_level;
  logic data_level;
  logic final_step;

  modport source (output valid, output clock_level, output data_level, output final_step,
                  input ready);
  modport sink   (input valid, input clock_level, input data_level, input final_step,
                  output ready);
endinterface

// ===== sv/led_driver_two_wire_serializer_core.sv =====
// Two-wire LED driver serializer: each request (command, brightness, address, data)
// becomes a run of pin steps, LSB first, one step per result. A command or brightness
// request gives 31 steps, an address 27, a data byte 24 or 28 with last; rejected or
// empty requests give none. The step sequencer loads each job, then emits one step per
// cycle unless the output stalls; the front end takes requests into a two-entry job
// queue while the sequencer works. Depends on ldtw_pkg, ldtw_chan_if, ldtw_front,
// ldtw_queue, ldtw_back and the defines header.
`include "led_driver_two_wire_serializer_core_defines.svh"

module led_driver_two_wire_serializer_core (
  input  logic            clk,
  input  logic            rst_n,
  ldtw_in_if.sink         in_ch,
  ldtw_out_if.source      out_ch
);

  ldtw_pkg::q_stat_t q_stat;
  ldtw_pkg::job_t    push_job;
  ldtw_pkg::job_t    head_job;
  logic              push;
  logic              pop;

  ldtw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_operation (in_ch.operation),
    .in_value     (in_ch.value),
    .in_last      (in_ch.last),
    .q_stat       (q_stat),
    .push         (push),
    .push_job     (push_job)
  );

  ldtw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  ldtw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .head_job        (head_job),
    .pop             (pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_clock_level (out_ch.clock_level),
    .out_data_level  (out_ch.data_level),
    .out_final_step  (out_ch.final_step)
  );

  `LDTW_ASSERT_IMP(a_no_push_full, push, !q_stat.full)
  `LDTW_ASSERT_IMP(a_no_pop_empty, pop, q_stat.nonempty)
  `LDTW_ASSERT_IMP(a_final_clk_high, out_ch.valid && out_ch.final_step, out_ch.clock_level)

endmodule

// ===== sv/ldtw_front.sv =====
// Front end: accepts requests, tracks frame mode, turns requests into queued jobs.
// Depends on ldtw_pkg.
module ldtw_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_operation,
  input  logic [7:0]       in_value,
  input  logic             in_last,
  input  ldtw_pkg::q_stat_t q_stat,
  output logic             push,
  output ldtw_pkg::job_t   push_job
);

  ldtw_pkg::mode_t mode_r;
  ldtw_pkg::mode_t mode_nxt;
  logic            acc;
  logic            idle;

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;
  assign idle     = (mode_r != ldtw_pkg::MODE_OPEN) && (mode_r != ldtw_pkg::MODE_DROP);

  always_comb begin
    mode_nxt          = mode_r;
    push              = 1'b0;
    push_job.start    = 1'b0;
    push_job.stop     = 1'b0;
    push_job.byte_val = in_value;
    if (acc) begin
      case (ldtw_pkg::op_t'(in_operation))
        ldtw_pkg::OP_CMD: begin
          if (idle) begin
            push           = 1'b1;
            push_job.start = 1'b1;
            push_job.stop  = 1'b1;
          end
        end
        ldtw_pkg::OP_BRT: begin
          if (idle) begin
            push              = 1'b1;
            push_job.start    = 1'b1;
            push_job.stop     = 1'b1;
            push_job.byte_val = ldtw_pkg::brt_encode(in_value);
          end
        end
        ldtw_pkg::OP_ADDR: begin
          if (idle) begin
            if (in_value > ldtw_pkg::ADDR_MAX) begin
              mode_nxt = in_last ? ldtw_pkg::MODE_IDLE : ldtw_pkg::MODE_DROP;
            end else if (in_last) begin
              mode_nxt = ldtw_pkg::MODE_IDLE;
            end else begin
              push              = 1'b1;
              push_job.start    = 1'b1;
              push_job.byte_val = ldtw_pkg::ADDR_BASE | in_value;
              mode_nxt          = ldtw_pkg::MODE_OPEN;
            end
          end
        end
        ldtw_pkg::OP_DATA: begin
          if (mode_r == ldtw_pkg::MODE_OPEN) begin
            push          = 1'b1;
            push_job.stop = in_last;
            if (in_last) begin
              mode_nxt = ldtw_pkg::MODE_IDLE;
            end
          end else if (mode_r == ldtw_pkg::MODE_DROP) begin
            if (in_last) begin
              mode_nxt = ldtw_pkg::MODE_IDLE;
            end
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ldtw_pkg::MODE_IDLE;
    end else begin
      mode_r <= mode_nxt;
    end
  end

endmodule

// ===== sv/ldtw_queue.sv =====
// Two-entry job queue between front end and step sequencer.
// Depends on ldtw_pkg.
module ldtw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ldtw_pkg::job_t    push_job,
  input  logic              pop,
  output ldtw_pkg::job_t    head_job,
  output ldtw_pkg::q_stat_t q_stat
);

  ldtw_pkg::job_t mem_r [2];
  logic           wr_ptr_r;
  logic           wr_ptr_nxt;
  logic           rd_ptr_r;
  logic           rd_ptr_nxt;
  logic [1:0]     cnt_r;
  logic [1:0]     cnt_nxt;

  assign head_job        = mem_r[rd_ptr_r];
  assign q_stat.full     = (cnt_r == 2'd2);
  assign q_stat.nonempty = (cnt_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== sv/ldtw_back.sv =====
// Step sequencer: plays start, bit and stop steps of each job, one step per cycle
// while the registered output stage is empty or read. Depends on ldtw_pkg.
module ldtw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ldtw_pkg::q_stat_t q_stat,
  input  ldtw_pkg::job_t    head_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_clock_level,
  output logic              out_data_level,
  output logic              out_final_step
);

  ldtw_pkg::phase_t phase_r;
  ldtw_pkg::phase_t phase_nxt;
  logic [1:0]       sub_r;
  logic [1:0]       sub_nxt;
  logic [2:0]       bit_r;
  logic [2:0]       bit_nxt;
  logic [7:0]       byte_r;
  logic [7:0]       byte_nxt;
  logic             stop_r;
  logic             stop_nxt;
  logic             clk_pin_r;
  logic             data_pin_r;
  logic             ov_r;
  logic             oc_r;
  logic             od_r;
  logic             of_r;
  logic             adv;
  logic             step_clk;
  logic             step_data;
  logic             step_final;

  assign pop = (phase_r == ldtw_pkg::BK_IDLE) && q_stat.nonempty;
  assign adv = (phase_r != ldtw_pkg::BK_IDLE) && (!ov_r || out_ready);

  // Step outputs: pin levels after the current step.
  always_comb begin
    step_clk   = clk_pin_r;
    step_data  = data_pin_r;
    step_final = 1'b0;
    case (phase_r)
      ldtw_pkg::BK_START: begin
        case (sub_r)
          2'd0:    step_clk  = 1'b1;
          2'd1:    step_data = 1'b1;
          default: step_data = 1'b0;
        endcase
      end
      ldtw_pkg::BK_BITS: begin
        case (sub_r)
          2'd0: step_clk  = 1'b0;
          2'd1: step_data = byte_r[0];
          default: begin
            step_clk   = 1'b1;
            step_final = (bit_r == 3'd7) && !stop_r;
          end
        endcase
      end
      ldtw_pkg::BK_STOP: begin
        case (sub_r)
          2'd0: step_clk  = 1'b0;
          2'd1: step_data = 1'b0;
          2'd2: step_clk  = 1'b1;
          default: begin
            step_data  = 1'b1;
            step_final = 1'b1;
          end
        endcase
      end
      default: begin
        step_final = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    sub_nxt   = sub_r;
    bit_nxt   = bit_r;
    byte_nxt  = byte_r;
    stop_nxt  = stop_r;
    case (phase_r)
      ldtw_pkg::BK_IDLE: begin
        if (pop) begin
          phase_nxt = head_job.start ? ldtw_pkg::BK_START : ldtw_pkg::BK_BITS;
          sub_nxt   = 2'd0;
          bit_nxt   = 3'd0;
          byte_nxt  = head_job.byte_val;
          stop_nxt  = head_job.stop;
        end
      end
      ldtw_pkg::BK_START: begin
        if (adv) begin
          if (sub_r == 2'd2) begin
            phase_nxt = ldtw_pkg::BK_BITS;
            sub_nxt   = 2'd0;
          end else begin
            sub_nxt = sub_r + 2'd1;
          end
        end
      end
      ldtw_pkg::BK_BITS: begin
        if (adv) begin
          if (sub_r == 2'd2) begin
            sub_nxt  = 2'd0;
            bit_nxt  = bit_r + 3'd1;
            byte_nxt = {1'b0, byte_r[7:1]};
            if (bit_r == 3'd7) begin
              phase_nxt = stop_r ? ldtw_pkg::BK_STOP : ldtw_pkg::BK_IDLE;
            end
          end else begin
            sub_nxt = sub_r + 2'd1;
          end
        end
      end
      ldtw_pkg::BK_STOP: begin
        if (adv) begin
          if (sub_r == 2'd3) begin
            phase_nxt = ldtw_pkg::BK_IDLE;
            sub_nxt   = 2'd0;
          end else begin
            sub_nxt = sub_r + 2'd1;
          end
        end
      end
      default: begin
        phase_nxt = ldtw_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= ldtw_pkg::BK_IDLE;
      sub_r      <= 2'd0;
      bit_r      <= 3'd0;
      stop_r     <= 1'b0;
      clk_pin_r  <= 1'b1;
      data_pin_r <= 1'b1;
      ov_r       <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      sub_r   <= sub_nxt;
      bit_r   <= bit_nxt;
      stop_r  <= stop_nxt;
      if (adv) begin
        clk_pin_r  <= step_clk;
        data_pin_r <= step_data;
        ov_r       <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    if (adv) begin
      oc_r <= step_clk;
      od_r <= step_data;
      of_r <= step_final;
    end
  end

  assign out_valid       = ov_r;
  assign out_clock_level = oc_r;
  assign out_data_level  = od_r;
  assign out_final_step  = of_r;

endmodule

// ===== verif/led_driver_two_wire_serializer_core_tb.sv =====
// Testbench for led_driver_two_wire_serializer_core: directed table then random requests,
// each pin step checked against an in-bench model of the link. Uses ldtw_pkg and the
// ldtw_in_if / ldtw_out_if channel interfaces.
module led_driver_two_wire_serializer_core_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_REQS = 50;

  typedef struct packed {
    logic clock_level;
    logic data_level;
    logic final_step;
  } pin_step_t;

  typedef struct packed {
    ldtw_pkg::op_t op;
    logic [7:0]    value;
    logic          last;
    int            steps;
  } req_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ldtw_in_if  req_ch ();
  ldtw_out_if step_ch ();

  led_driver_two_wire_serializer_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (step_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // steps = -1: checked against the model only
  req_row_t directed_rows [0:23] = '{
    '{ldtw_pkg::OP_CMD,  8'h00, 1'b0, 31},
    '{ldtw_pkg::OP_CMD,  8'hFF, 1'b1, 31},
    '{ldtw_pkg::OP_BRT,  8'h00, 1'b0, 31},
    '{ldtw_pkg::OP_BRT,  8'h08, 1'b0, 31},
    '{ldtw_pkg::OP_BRT,  8'hFF, 1'b1, 31},
    '{ldtw_pkg::OP_BRT,  8'h03, 1'b0, -1},
    '{ldtw_pkg::OP_DATA, 8'hA5, 1'b1, 0},
    '{ldtw_pkg::OP_ADDR, 8'h00, 1'b0, 27},
    '{ldtw_pkg::OP_CMD,  8'h55, 1'b0, 0},
    '{ldtw_pkg::OP_BRT,  8'h04, 1'b1, 0},
    '{ldtw_pkg::OP_ADDR, 8'h03, 1'b0, 0},
    '{ldtw_pkg::OP_DATA, 8'h00, 1'b0, 24},
    '{ldtw_pkg::OP_DATA, 8'hFF, 1'b1, 28},
    '{ldtw_pkg::OP_ADDR, 8'h0F, 1'b1, 0},
    '{ldtw_pkg::OP_ADDR, 8'h10, 1'b1, 0},
    '{ldtw_pkg::OP_ADDR, 8'hFF, 1'b0, 0},
    '{ldtw_pkg::OP_DATA, 8'h12, 1'b0, 0},
    '{ldtw_pkg::OP_CMD,  8'h40, 1'b0, 0},
    '{ldtw_pkg::OP_ADDR, 8'h02, 1'b0, 0},
    '{ldtw_pkg::OP_DATA, 8'h34, 1'b1, 0},
    '{ldtw_pkg::OP_ADDR, 8'h0F, 1'b0, 27},
    '{ldtw_pkg::OP_DATA, 8'h5A, 1'b1, 28},
    '{ldtw_pkg::OP_BRT,  8'h01, 1'b0, 31},
    '{ldtw_pkg::OP_CMD,  8'h40, 1'b1, 31}
  };

  pin_step_t       pin_steps_due[$];
  ldtw_pkg::mode_t link_mode;
  logic            line_clk;
  logic            line_dat;
  int              fail_count = 0;
  int              served_reqs = 0;
  int              cycle_count = 0;
  int              idle_pct = 0;
  int              stall_pct = 0;
  int              req_steps_typed;

  function automatic void pin_step(input bit on_clock, input logic lvl);
    pin_step_t s;
    if (on_clock) line_clk = lvl;
    else line_dat = lvl;
    s.clock_level = line_clk;
    s.data_level  = line_dat;
    s.final_step  = 1'b0;
    pin_steps_due.push_back(s);
  endfunction

  function automatic void link_start();
    pin_step(1'b1, 1'b1);
    pin_step(1'b0, 1'b1);
    pin_step(1'b0, 1'b0);
  endfunction

  function automatic void link_byte(input logic [7:0] b);
    for (int i = 0; i < 8; i++) begin
      pin_step(1'b1, 1'b0);
      pin_step(1'b0, b[i]);
      pin_step(1'b1, 1'b1);
    end
  endfunction

  function automatic void link_stop();
    pin_step(1'b1, 1'b0);
    pin_step(1'b0, 1'b0);
    pin_step(1'b1, 1'b1);
    pin_step(1'b0, 1'b1);
  endfunction

  // Appends the pin steps a request causes; returns their number.
  function automatic int predict_pin_steps(input ldtw_pkg::op_t op, input logic [7:0] val,
                                           input logic lst, output bit in_order);
    int        n0;
    bit        idle;
    logic [7:0] lvl;
    pin_step_t tail;
    n0 = pin_steps_due.size();
    idle = (link_mode != ldtw_pkg::MODE_OPEN) && (link_mode != ldtw_pkg::MODE_DROP);
    in_order = 1'b1;
    case (op)
      ldtw_pkg::OP_CMD: begin
        if (idle) begin
          link_start();
          link_byte(val);
          link_stop();
        end else in_order = 1'b0;
      end
      ldtw_pkg::OP_BRT: begin
        if (idle) begin
          lvl = (val > ldtw_pkg::BRT_MAX) ? ldtw_pkg::BRT_MAX : val;
          if (lvl != 8'd0) lvl = (lvl - ldtw_pkg::BRT_OFFSET) | ldtw_pkg::BRT_ON;
          link_start();
          link_byte(ldtw_pkg::BRT_BASE | lvl);
          link_stop();
        end else in_order = 1'b0;
      end
      ldtw_pkg::OP_ADDR: begin
        if (!idle) begin
          in_order = 1'b0;
        end else if (val > ldtw_pkg::ADDR_MAX) begin
          link_mode = lst ? ldtw_pkg::MODE_IDLE : ldtw_pkg::MODE_DROP;
        end else if (lst) begin
          link_mode = ldtw_pkg::MODE_IDLE;
        end else begin
          link_start();
          link_byte(ldtw_pkg::ADDR_BASE | val);
          link_mode = ldtw_pkg::MODE_OPEN;
        end
      end
      default: begin
        if (link_mode == ldtw_pkg::MODE_OPEN) begin
          link_byte(val);
          if (lst) begin
            link_stop();
            link_mode = ldtw_pkg::MODE_IDLE;
          end
        end else if (link_mode == ldtw_pkg::MODE_DROP) begin
          if (lst) link_mode = ldtw_pkg::MODE_IDLE;
        end else in_order = 1'b0;
      end
    endcase
    if (pin_steps_due.size() > n0) begin
      tail = pin_steps_due.pop_back();
      tail.final_step = 1'b1;
      pin_steps_due.push_back(tail);
    end
    return pin_steps_due.size() - n0;
  endfunction

  always @(posedge clk) begin
    pin_step_t due;
    pin_step_t got;
    int        n;
    bit        ordered;
    if (!rst_n) begin
      link_mode = ldtw_pkg::MODE_IDLE;
      line_clk = 1'b1;
      line_dat = 1'b1;
      pin_steps_due.delete();
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        n = predict_pin_steps(ldtw_pkg::op_t'(req_ch.operation), req_ch.value,
                              req_ch.last, ordered);
        if (ordered) served_reqs <= served_reqs + 1;
        if (req_steps_typed >= 0 && n != req_steps_typed) begin
          $display("%0t: request op=%0d value=%h last=%b: expected %0d steps, model gives %0d",
                   $time, req_ch.operation, req_ch.value, req_ch.last, req_steps_typed, n);
          fail_count++;
        end
      end
      if (step_ch.valid && step_ch.ready) begin
        got.clock_level = step_ch.clock_level;
        got.data_level  = step_ch.data_level;
        got.final_step  = step_ch.final_step;
        if (pin_steps_due.size() == 0) begin
          $display("%0t: unexpected pin step clk=%b dat=%b final=%b",
                   $time, got.clock_level, got.data_level, got.final_step);
          fail_count++;
        end else begin
          due = pin_steps_due.pop_front();
          if (got.clock_level !== due.clock_level || got.data_level !== due.data_level ||
              got.final_step !== due.final_step) begin
            $display("%0t: step mismatch exp clk=%b dat=%b fin=%b got clk=%b dat=%b fin=%b",
                     $time, due.clock_level, due.data_level, due.final_step,
                     got.clock_level, got.data_level, got.final_step);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    step_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_req(input ldtw_pkg::op_t op, input logic [7:0] val, input logic lst,
                          input int typed);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid     <= 1'b0;
      req_ch.operation <= 2'($urandom_range(3));
      req_ch.value     <= 8'($urandom);
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.value     <= val;
    req_ch.last      <= lst;
    req_steps_typed  <= typed;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pin_steps_due.size() != 0) @(posedge clk);
  endtask

  task automatic random_transaction();
    int         kind;
    int         nd;
    logic [7:0] addr;
    kind = $urandom_range(99);
    if (kind < 20) begin
      send_req(ldtw_pkg::OP_CMD, 8'($urandom), 1'($urandom), -1);
    end else if (kind < 35) begin
      send_req(ldtw_pkg::OP_BRT,
               ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(9)),
               1'($urandom), -1);
    end else if (kind < 85) begin
      addr = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 16)) : 8'($urandom_range(15));
      nd = $urandom_range(4);
      send_req(ldtw_pkg::OP_ADDR, addr, nd == 0, -1);
      for (int k = 1; k <= nd; k++) send_req(ldtw_pkg::OP_DATA, 8'($urandom), k == nd, -1);
    end else begin
      send_req(ldtw_pkg::op_t'($urandom_range(3)), 8'($urandom), 1'($urandom), -1);
    end
  endtask

  initial begin
    int idle_set [0:3]  = '{0, 72, 0, 33};
    int stall_set [0:3] = '{0, 0, 72, 33};
    int base;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.operation = ldtw_pkg::OP_CMD;
    req_ch.value = 8'h00;
    req_ch.last = 1'b0;
    req_steps_typed = -1;
    step_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 24; i++)
      send_req(directed_rows[i].op, directed_rows[i].value, directed_rows[i].last,
               directed_rows[i].steps);
    req_steps_typed <= -1;
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_set[ph];
      stall_pct <= stall_set[ph];
      base = served_reqs;
      while (served_reqs - base < PHASE_REQS) random_transaction();
      if (ph == 1) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
